### rtl/core/tremolo_lfo_modulator_top_macros.svh
// Assertion helpers for the tremolo checker. Both sample on the rising clk edge
// and are disabled while arst_n is low.
`ifndef TREMOLO_LFO_MODULATOR_TOP_MACROS_SVH
`define TREMOLO_LFO_MODULATOR_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TLFO_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tremolo check failed");

// The consequent must hold in the cycle after the antecedent.
`define TLFO_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tremolo check failed");

`endif

### rtl/core/tlfo_pkg.sv
package tlfo_pkg;

	localparam int Q_W          = 17;
	localparam int PHASE_W      = 32;
	localparam int CFG_INDEX_W  = 3;
	localparam int CFG_DATA_W   = 32;
	localparam int SINE_DEPTH   = 256;
	localparam int SINE_IDX_W   = $clog2(SINE_DEPTH);
	localparam int SINE_VAL_W   = 16;

	localparam logic [Q_W-1:0] Q_ONE  = 17'd65536;
	localparam logic [Q_W-1:0] Q_HALF = 17'd32768;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef enum logic [1:0] {
		SHAPE_SINE    = 2'd0,
		SHAPE_RISING  = 2'd1,
		SHAPE_FALLING = 2'd2,
		SHAPE_SQUARE  = 2'd3
	} shape_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_WAVE_SHAPE   = 3'd0,
		REG_PHASE_STEP   = 3'd1,
		REG_MOD_DEPTH    = 3'd2,
		REG_SMOOTH_COEFF = 3'd3
	} cfg_reg_t;

	typedef struct packed {
		logic en;
		logic accum;
	} mac_ctrl_t;

	typedef logic [SINE_DEPTH:0][SINE_VAL_W-1:0] sine_rom_t;

	// Quarter-wave sine in Q15 from a fixed-point Taylor series, evaluated at elaboration.
	function automatic sine_rom_t build_sine_rom();
		sine_rom_t rom;
		logic [63:0] t;
		logic [63:0] t2;
		logic [63:0] term;
		logic [63:0] r;
		logic signed [63:0] sum;
		int i;
		rom = '0;
		for (i = 0; i <= SINE_DEPTH; i++) begin
			t    = (64'(i) * HALF_PI_Q30) / SINE_DEPTH;
			t2   = (t * t) >> 30;
			sum  = $signed(t);
			term = ((t * t2) >> 30) / 64'd6;
			sum  = sum - $signed(term);
			term = ((term * t2) >> 30) / 64'd20;
			sum  = sum + $signed(term);
			term = ((term * t2) >> 30) / 64'd42;
			sum  = sum - $signed(term);
			term = ((term * t2) >> 30) / 64'd72;
			sum  = sum + $signed(term);
			term = ((term * t2) >> 30) / 64'd110;
			sum  = sum - $signed(term);
			term = ((term * t2) >> 30) / 64'd156;
			sum  = sum + $signed(term);
			if (sum < 0) begin
				sum = 0;
			end
			r = ($unsigned(sum) + 64'd16384) >> 15;
			if (r > 64'd32768) begin
				r = 64'd32768;
			end
			rom[i] = r[SINE_VAL_W-1:0];
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

### rtl/core/tlfo_mac.sv
module tlfo_mac
	import tlfo_pkg::*;
#(
	parameter int A_W   = 25,
	parameter int B_W   = 18,
	parameter int ACC_W = 44
) (
	input  logic                    clk,
	input  mac_ctrl_t               ctrl,
	input  logic signed [A_W-1:0]   op_a,
	input  logic signed [B_W-1:0]   op_b,
	output logic signed [ACC_W-1:0] acc
);

	logic signed [ACC_W-1:0]   acc_q;
	logic signed [A_W+B_W-1:0] prod;

	assign prod = op_a * op_b;

	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			acc_q <= (ctrl.accum ? acc_q : '0) + ACC_W'(prod);
		end
	end

	assign acc = acc_q;

endmodule

### rtl/core/tlfo_wave.sv
module tlfo_wave
	import tlfo_pkg::*;
(
	input  logic               clk,
	input  logic               en,
	input  shape_t             shape,
	input  logic [PHASE_W-1:0] phase,
	output logic [Q_W-1:0]     wave
);

	logic [1:0]            quad;
	logic [SINE_IDX_W-1:0] idx;
	logic [SINE_IDX_W:0]   rom_addr;
	logic [SINE_VAL_W-1:0] sine_mag;
	logic [Q_W-1:0]        wave_next;
	logic [Q_W-1:0]        wave_q;

	assign quad = phase[PHASE_W-1 -: 2];
	assign idx  = phase[PHASE_W-3 -: SINE_IDX_W];

	// Odd quadrants run the table backward.
	assign rom_addr = quad[0] ? ((SINE_IDX_W+1)'(SINE_DEPTH) - {1'b0, idx}) : {1'b0, idx};
	assign sine_mag = SINE_ROM[rom_addr];

	always_comb begin
		case (shape)
			SHAPE_RISING:  wave_next = {1'b0, phase[PHASE_W-1 -: 16]};
			SHAPE_FALLING: wave_next = Q_ONE - {1'b0, phase[PHASE_W-1 -: 16]};
			SHAPE_SQUARE:  wave_next = phase[PHASE_W-1] ? '0 : Q_ONE;
			default: begin
				wave_next = quad[1] ? (Q_HALF - Q_W'(sine_mag)) : (Q_HALF + Q_W'(sine_mag));
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wave_q <= wave_next;
		end
	end

	assign wave = wave_q;

endmodule

### rtl/core/tremolo_lfo_modulator_top.sv
// Channel   Handshake              Payload
// input     in_valid / in_stall    sample_left, sample_right
// output    out_valid / out_stall  out_left, out_right
// config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A frame runs through the wave, multiply, smoothing, gain and store states for each channel
// in turn on the single multiply-accumulate unit that does every product; the input reopens
// as the frame reaches the output register, so frames are accepted one at a time.
// A zero phase step sends a frame straight to the done state, leaving the LFO state alone.
// arst_n clears phases, smoothed waves and registers (smoothing coefficient to one).
// A stalled output holds the finished frame; one more frame may be in work behind it.
module tremolo_lfo_modulator_top
	import tlfo_pkg::*;
#(
	parameter int CHANNELS     = 2,
	parameter int SAMPLE_WIDTH = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_left,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_right,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [SAMPLE_WIDTH-1:0] out_left,
	output logic signed [SAMPLE_WIDTH-1:0] out_right,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [CFG_INDEX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]          cfg_data
);

	localparam int A_W   = ((SAMPLE_WIDTH > Q_W) ? SAMPLE_WIDTH : Q_W) + 1;
	localparam int B_W   = Q_W + 1;
	localparam int ACC_W = A_W + B_W + 1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WAVE,
		ST_MUL_Y,
		ST_MUL_W,
		ST_SMOOTH,
		ST_MUL_D,
		ST_GAIN,
		ST_MUL_S,
		ST_STORE,
		ST_DONE
	} state_t;

	state_t             state_q;
	logic               ch_q;
	logic               out_valid_q;
	logic [PHASE_W-1:0] phase_q [2];
	logic [Q_W-1:0]     y_q [2];

	shape_t             shape_q;
	logic [PHASE_W-1:0] step_q;
	logic [Q_W-1:0]     depth_q;
	logic [Q_W-1:0]     coeff_q;

	logic signed [SAMPLE_WIDTH-1:0] smp_q [2];
	logic signed [SAMPLE_WIDTH-1:0] res_q [2];
	logic signed [SAMPLE_WIDTH-1:0] out_q [2];
	logic [Q_W-1:0]                 gain_q;

	logic [Q_W-1:0]          a_sat;
	logic [Q_W-1:0]          d_sat;
	logic                    in_beat;
	logic                    out_free;
	logic                    last_ch;
	mac_ctrl_t               mac_ctrl;
	logic signed [A_W-1:0]   mac_a;
	logic signed [B_W-1:0]   mac_b;
	logic signed [ACC_W-1:0] mac_acc;
	logic [ACC_W-1:0]        rnd_sum;
	logic [Q_W:0]            rnd_q16;
	logic [Q_W-1:0]          y_new;
	logic [Q_W-1:0]          gain_new;
	logic [Q_W-1:0]          wave;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shape_q <= SHAPE_SINE;
			step_q  <= '0;
			depth_q <= '0;
			coeff_q <= Q_ONE;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_WAVE_SHAPE:   shape_q <= shape_t'(cfg_data[1:0]);
				REG_PHASE_STEP:   step_q  <= cfg_data;
				REG_MOD_DEPTH:    depth_q <= cfg_data[Q_W-1:0];
				REG_SMOOTH_COEFF: coeff_q <= cfg_data[Q_W-1:0];
				default: ;
			endcase
		end
	end

	assign a_sat = (coeff_q > Q_ONE) ? Q_ONE : coeff_q;
	assign d_sat = (depth_q > Q_ONE) ? Q_ONE : depth_q;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_beat   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign last_ch   = (ch_q == 1'(CHANNELS - 1));
	assign out_valid = out_valid_q;
	assign out_left  = out_q[0];
	assign out_right = out_q[1];

	always_comb begin
		mac_ctrl = '{en: 1'b0, accum: 1'b0};
		mac_a    = '0;
		mac_b    = '0;
		case (state_q)
			ST_MUL_Y: begin
				mac_ctrl = '{en: 1'b1, accum: 1'b0};
				mac_a    = A_W'(y_q[ch_q]);
				mac_b    = B_W'(Q_ONE - a_sat);
			end
			ST_MUL_W: begin
				mac_ctrl = '{en: 1'b1, accum: 1'b1};
				mac_a    = A_W'(wave);
				mac_b    = B_W'(a_sat);
			end
			ST_MUL_D: begin
				mac_ctrl = '{en: 1'b1, accum: 1'b0};
				mac_a    = A_W'(d_sat);
				mac_b    = B_W'(y_q[ch_q]);
			end
			ST_MUL_S: begin
				mac_ctrl = '{en: 1'b1, accum: 1'b0};
				mac_a    = A_W'(smp_q[ch_q]);
				mac_b    = B_W'(gain_q);
			end
			default: ;
		endcase
	end

	tlfo_mac #(
		.A_W   (A_W),
		.B_W   (B_W),
		.ACC_W (ACC_W)
	) u_mac (
		.clk  (clk),
		.ctrl (mac_ctrl),
		.op_a (mac_a),
		.op_b (mac_b),
		.acc  (mac_acc)
	);

	tlfo_wave u_wave (
		.clk   (clk),
		.en    (state_q == ST_WAVE),
		.shape (shape_q),
		.phase (phase_q[ch_q]),
		.wave  (wave)
	);

	// Round a Q1.16 product back to Q1.16; both uses stay non-negative.
	assign rnd_sum  = $unsigned(mac_acc) + ACC_W'(Q_HALF);
	assign rnd_q16  = rnd_sum[Q_W+16:16];
	assign y_new    = (rnd_q16 > (Q_W+1)'(Q_ONE)) ? Q_ONE : rnd_q16[Q_W-1:0];
	assign gain_new = Q_W'((Q_W+1)'(Q_ONE) - (Q_W+1)'(d_sat) + rnd_q16);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ch_q        <= 1'b0;
			out_valid_q <= 1'b0;
			phase_q[0]  <= '0;
			phase_q[1]  <= '0;
			y_q[0]      <= '0;
			y_q[1]      <= '0;
		end else begin
			// hold a stalled beat, present a finished frame once the register frees up
			out_valid_q <= (state_q == ST_DONE && out_free) || (out_valid_q && out_stall);
			case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						ch_q    <= 1'b0;
						state_q <= (step_q == '0) ? ST_DONE : ST_WAVE;
					end
				end
				ST_WAVE:   state_q <= ST_MUL_Y;
				ST_MUL_Y:  state_q <= ST_MUL_W;
				ST_MUL_W:  state_q <= ST_SMOOTH;
				ST_SMOOTH: begin
					y_q[ch_q] <= y_new;
					state_q   <= ST_MUL_D;
				end
				ST_MUL_D:  state_q <= ST_GAIN;
				ST_GAIN:   state_q <= ST_MUL_S;
				ST_MUL_S:  state_q <= ST_STORE;
				ST_STORE: begin
					phase_q[ch_q] <= phase_q[ch_q] + step_q;
					if (last_ch) begin
						state_q <= ST_DONE;
					end else begin
						ch_q    <= ch_q + 1'b1;
						state_q <= ST_WAVE;
					end
				end
				ST_DONE: begin
					// hold the frame until the output register frees up
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			smp_q[0] <= sample_left;
			smp_q[1] <= sample_right;
			res_q[0] <= sample_left;
			res_q[1] <= (CHANNELS >= 2) ? sample_right : '0;
		end
		if (state_q == ST_GAIN) begin
			gain_q <= gain_new;
		end
		if (state_q == ST_STORE) begin
			// floor of the product over 2^16, wrapped to the sample width
			res_q[ch_q] <= mac_acc[SAMPLE_WIDTH+15:16];
		end
		if (state_q == ST_DONE && out_free) begin
			out_q[0] <= res_q[0];
			out_q[1] <= res_q[1];
		end
	end

endmodule

### rtl/core/tlfo_checker.sv
`include "tremolo_lfo_modulator_top_macros.svh"

module tlfo_checker #(
	parameter int SAMPLE_WIDTH = 24
) (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_stall,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic [SAMPLE_WIDTH-1:0] out_left,
	input logic [SAMPLE_WIDTH-1:0] out_right
);

	// a stalled output beat keeps its payload
	`TLFO_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_left) && $stable(out_right))

	// an accepted frame blocks the input until it is done
	`TLFO_ASSERT_NEXT(a_busy_after_beat, in_valid && !in_stall, in_stall)

	// the input reopens only as a finished frame is presented
	`TLFO_ASSERT_SAME(a_reopen_with_result, $fell(in_stall), out_valid)

	// a new result appears only as the sequencer returns to idle
	`TLFO_ASSERT_SAME(a_result_at_idle, $rose(out_valid), !in_stall)

endmodule

bind tremolo_lfo_modulator_top tlfo_checker #(
	.SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_tlfo_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_left  (out_left),
	.out_right (out_right)
);

### tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import tlfo_pkg::*;

	localparam int SW = 24;
	localparam longint unsigned UNITY = 65536;
	localparam longint unsigned HALF = 32768;
	localparam int IDLE_PCT = 36;
	localparam int HOLD_CYCLES = 200;
	localparam int SETTLE_CYCLES = 24;
	localparam int QUIET_LIMIT = 2000;
	localparam logic [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};
	localparam logic [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 3'd4;

	typedef struct packed {
		logic [SW-1:0] left;
		logic [SW-1:0] right;
	} frame_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [SW-1:0] sample_left = '0;
	logic [SW-1:0] sample_right = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [SW-1:0] out_left;
	logic [SW-1:0] out_right;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// shadow of the block's registers and LFO state
	shape_t lfo_shape = SHAPE_SINE;
	logic [31:0] lfo_step = '0;
	longint unsigned lfo_depth = 0;
	longint unsigned lfo_coeff = UNITY;
	logic [31:0] lfo_phase [2] = '{32'd0, 32'd0};
	longint unsigned lfo_smooth [2] = '{0, 0};
	longint unsigned sine_q15 [0:SINE_DEPTH];

	frame_t frames_due [$];
	int mismatch_count = 0;
	int quiet_cycles = 0;
	int hold_ticket = 0;
	bit calm = 1'b0;

	tremolo_lfo_modulator_top #(
		.CHANNELS(2),
		.SAMPLE_WIDTH(SW)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample_left(sample_left),
		.sample_right(sample_right),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_left(out_left),
		.out_right(out_right),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// quarter-wave sine in Q15 from a truncated Taylor series
	initial begin
		longint unsigned t, t2, term, r;
		longint sum;
		for (int i = 0; i <= SINE_DEPTH; i++) begin
			t = (longint'(i) * HALF_PI_Q30) / SINE_DEPTH;
			t2 = (t * t) >> 30;
			term = t;
			sum = longint'(t);
			for (int k = 1; k <= 6; k++) begin
				term = ((term * t2) >> 30) / longint'((2 * k) * (2 * k + 1));
				if (k % 2 == 1) begin
					sum -= longint'(term);
				end else begin
					sum += longint'(term);
				end
			end
			if (sum < 0) begin
				sum = 0;
			end
			r = (longint'(sum) + 16384) >> 15;
			sine_q15[i] = (r > HALF) ? HALF : r;
		end
	end

	function automatic longint unsigned lfo_wave(logic [31:0] p);
		longint unsigned idx;
		longint unsigned s;
		case (lfo_shape)
			SHAPE_RISING: return p[31:16];
			SHAPE_FALLING: return UNITY - p[31:16];
			SHAPE_SQUARE: return p[31] ? 0 : UNITY;
			default: begin
				idx = (longint'(p[29:0]) * SINE_DEPTH) >> 30;
				if (idx > SINE_DEPTH) begin
					idx = SINE_DEPTH;
				end
				s = p[30] ? sine_q15[SINE_DEPTH - idx] : sine_q15[idx];
				return p[31] ? HALF - s : HALF + s;
			end
		endcase
	endfunction

	// advance the LFO of both channels and return the modulated frame
	function automatic frame_t predict_tremolo(logic [SW-1:0] left, logic [SW-1:0] right);
		frame_t res;
		logic [SW-1:0] smp [2];
		logic [SW-1:0] mod [2];
		longint unsigned a, d, w, y, g;
		longint prod, q;
		res.left = left;
		res.right = right;
		if (lfo_step == 0) begin
			return res;
		end
		a = (lfo_coeff > UNITY) ? UNITY : lfo_coeff;
		d = (lfo_depth > UNITY) ? UNITY : lfo_depth;
		smp[0] = left;
		smp[1] = right;
		for (int ch = 0; ch < 2; ch++) begin
			w = lfo_wave(lfo_phase[ch]);
			y = (lfo_smooth[ch] * (UNITY - a) + w * a + HALF) >> 16;
			if (y > UNITY) begin
				y = UNITY;
			end
			lfo_smooth[ch] = y;
			g = UNITY - d + ((d * y + HALF) >> 16);
			prod = longint'($signed(smp[ch])) * longint'(g);
			q = prod >>> 16;
			mod[ch] = q[SW-1:0];
			lfo_phase[ch] = lfo_phase[ch] + lfo_step;
		end
		res.left = mod[0];
		res.right = mod[1];
		return res;
	endfunction

	function automatic logic [SW-1:0] pick_sample();
		case ($urandom_range(15))
			0: return S_MIN;
			1: return S_MAX;
			2: return '0;
			default: return SW'($urandom());
		endcase
	endfunction

	task automatic send_frame(input logic [SW-1:0] left, input logic [SW-1:0] right);
		int gap;
		gap = 0;
		if (!calm) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				gap++;
			end
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample_left <= left;
		sample_right <= right;
		do @(posedge clk); while (in_stall);
		frames_due.push_back(predict_tremolo(left, right));
	endtask

	// drop valid, wait for every result, then let the pipeline go quiet
	task automatic settle_block();
		in_valid <= 1'b0;
		while (frames_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_WAVE_SHAPE: lfo_shape = shape_t'(data[1:0]);
			REG_PHASE_STEP: lfo_step = data;
			REG_MOD_DEPTH: lfo_depth = data[Q_W-1:0];
			REG_SMOOTH_COEFF: lfo_coeff = data[Q_W-1:0];
			default: ;
		endcase
	endtask

	task automatic program_lfo(input shape_t shape, input logic [31:0] step,
			input logic [31:0] depth, input logic [31:0] coeff, input bit stray);
		settle_block();
		if (stray) begin
			write_reg(REG_SPARE | CFG_INDEX_W'($urandom_range(3)), $urandom());
		end
		write_reg(REG_WAVE_SHAPE, ($urandom() & ~32'h3) | 32'(shape));
		write_reg(REG_PHASE_STEP, step);
		write_reg(REG_MOD_DEPTH, depth);
		write_reg(REG_SMOOTH_COEFF, coeff);
		cfg_valid <= 1'b0;
	endtask

	task automatic program_random(input bit force_run);
		logic [31:0] step, depth, coeff;
		case ($urandom_range(7))
			0: step = '0;
			1: step = '1;
			2: step = $urandom_range(256, 1);
			3, 4: step = $urandom() >> $urandom_range(24);
			default: step = $urandom();
		endcase
		if (force_run && step == 0) begin
			step = 32'h0100_0001;
		end
		case ($urandom_range(5))
			0: depth = '0;
			1: depth = 32'(UNITY);
			2: depth = $urandom();
			default: depth = $urandom_range(65536);
		endcase
		case ($urandom_range(7))
			0: coeff = '0;
			1: coeff = 32'd1;
			2: coeff = 32'(UNITY);
			3: coeff = $urandom();
			default: coeff = $urandom_range(65536, 1);
		endcase
		program_lfo(shape_t'($urandom_range(3)), step, depth, coeff, $urandom_range(3) == 0);
	endtask

	task automatic test_bypass_defaults();
		send_frame(S_MIN, S_MAX);
		send_frame(S_MAX, S_MIN);
		send_frame('0, '1);
		send_frame(24'd1, '0);
	endtask

	task automatic test_wave_shapes();
		shape_t shape;
		shape = shape.first();
		do begin
			program_lfo(shape, 32'h3000_0000, 32'(UNITY), 32'(UNITY), 1'b0);
			send_frame(S_MAX, S_MIN);
			send_frame(S_MIN, S_MAX);
			send_frame(pick_sample(), pick_sample());
			shape = shape.next();
		end while (shape != shape.first());
	endtask

	task automatic test_register_limits();
		// depth above range, frozen smoothing, ignored index
		program_lfo(SHAPE_SINE, '1, 32'h0001_FFFF, '0, 1'b1);
		repeat (3) send_frame(S_MIN, S_MAX);
		// both Q1.16 registers above range, slowest step
		program_lfo(SHAPE_SQUARE, 32'd1, '1, 32'h0001_FFFF, 1'b0);
		repeat (3) send_frame(S_MAX, S_MIN);
		program_lfo(SHAPE_RISING, 32'h8000_0000, '0, 32'd1, 1'b0);
		repeat (2) send_frame(pick_sample(), pick_sample());
	endtask

	task automatic test_random_settings();
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: program_lfo(SHAPE_SINE, 32'd1, 32'(UNITY), 32'd1, 1'b0);
				1: program_lfo(SHAPE_FALLING, '1, '0, 32'(UNITY), 1'b1);
				default: program_random(1'b0);
			endcase
			repeat (100) send_frame(pick_sample(), pick_sample());
		end
	endtask

	task automatic test_streaming();
		program_random(1'b1);
		calm = 1'b1;
		repeat (150) send_frame(pick_sample(), pick_sample());
		calm = 1'b0;
	endtask

	task automatic test_backpressure();
		program_random(1'b1);
		hold_ticket++;
		calm = 1'b1;
		repeat (40) send_frame(pick_sample(), pick_sample());
		calm = 1'b0;
		settle_block();
		repeat (20) send_frame(pick_sample(), pick_sample());
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_bypass_defaults();
		test_wave_shapes();
		test_register_limits();
		test_random_settings();
		test_streaming();
		test_backpressure();
		settle_block();
		if (mismatch_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// receiver: check each beat against the oldest prediction, then pick next stall
	always @(posedge clk) begin : receiver
		int hold_left;
		int hold_seen;
		frame_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (frames_due.size() == 0) begin
				$display("%0t: unexpected beat, got left %h right %h", $time, out_left,
					out_right);
				mismatch_count++;
			end else begin
				want = frames_due.pop_front();
				if (out_left !== want.left) begin
					$display("%0t: out_left expected %h, got %h", $time, want.left, out_left);
					mismatch_count++;
				end
				if (out_right !== want.right) begin
					$display("%0t: out_right expected %h, got %h", $time, want.right,
						out_right);
					mismatch_count++;
				end
			end
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (hold_seen != hold_ticket) begin
			hold_seen = hold_ticket;
			hold_left = HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

endmodule
